### design/movimm_pkg.sv
// shared types and constants for the move-immediate instruction encoder
// no dependencies; used by the top level and the port checker

package movimm_pkg;

   // operation codes carried on req_operation
   typedef enum logic [3:0] {
      OP_T1MOV      = 4'd0,
      OP_T2MOV      = 4'd1,
      OP_T3MOVW     = 4'd2,
      OP_MOVT       = 4'd3,
      OP_VMOVF32    = 4'd4,
      OP_A1MOV      = 4'd5,
      OP_A2MOVW     = 4'd6,
      OP_BKPT       = 4'd7,
      OP_NOP        = 4'd8,
      OP_THUMBROUND = 4'd9,
      OP_ARMROUND   = 4'd10
   } opcode_type;

   // fixed opcode bytes
   localparam logic [7:0] T1_MOVS_HI   = 8'b0010_0000;
   localparam logic [7:0] T2_MOV_HI    = 8'b1111_0000;
   localparam logic [7:0] T3_MOVW_HI   = 8'b1111_0010;
   localparam logic [7:0] MOVT_LO      = 8'b1100_0000;
   localparam logic [7:0] MOVW_LO      = 8'h40;
   localparam logic [7:0] T2_MOV_LO    = 8'h4F;
   localparam logic [7:0] VMOV_HI      = 8'b1110_1110;
   localparam logic [7:0] VMOV_LO      = 8'b1011_0000;
   localparam logic [7:0] A1_MOV_B2    = 8'b1010_0000;
   localparam logic [7:0] ARM_COND_AL  = 8'hE3;
   localparam logic [7:0] BKPT_HI      = 8'hBE;
   localparam logic [7:0] NOP_HI       = 8'hBF;
   localparam logic [3:0] VMOV_COPROC  = 4'hA;
   localparam logic [5:0] VFP_EXP_ONE  = 6'h1F;
   localparam logic [5:0] VFP_EXP_ZERO = 6'h20;

   // result lengths
   localparam logic [2:0] LEN_NONE   = 3'd0;
   localparam logic [2:0] LEN_NARROW = 3'd2;
   localparam logic [2:0] LEN_WIDE   = 3'd4;

endpackage

### design/mov_immediate_instruction_encoder_unit.sv
// move-immediate instruction encoder, top level
// depends on movimm_pkg; one input register stage, encode logic, one result register
//
//  channel   ports                                  direction   role
//  req       req_valid req_stall req_operation      in / out    item to encode or round
//            req_dest_register req_set_flags req_immediate
//  rsp       rsp_valid rsp_stall rsp_encoded        out / in    byte image, length, ok
//            rsp_length_bytes rsp_ok
//
// one item per cycle sustained while rsp_stall is low; an accepted item passes through the
// input register and then the result register before rsp_valid rises for it
// the input register and the result register each hold one item, so the block
// can take one more item while a finished result waits on rsp_stall
// rsp_stall reaches req_stall only when both registers are full
// reset (synchronous, active high) clears the two valid flags; payload is not reset

module mov_immediate_instruction_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic [7:0]  req_dest_register,
   input  logic        req_set_flags,
   input  logic [31:0] req_immediate,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_encoded,
   output logic [2:0]  rsp_length_bytes,
   output logic        rsp_ok
);

   localparam logic [5:0] VFP_EXP_ONE_L  = movimm_pkg::VFP_EXP_ONE;
   localparam logic [5:0] VFP_EXP_ZERO_L = movimm_pkg::VFP_EXP_ZERO;

   // input register stage
   logic        in_valid_ff;
   logic [3:0]  op_ff;
   logic [7:0]  rd_ff;
   logic        s_ff;
   logic [31:0] v_ff;

   // result register stage
   logic        out_valid_ff;
   logic [31:0] enc_ff;
   logic [2:0]  len_ff;
   logic        ok_ff;

   logic        out_free;
   logic        move_out;
   logic        take_in;

   // encode logic results
   logic [31:0] enc_in;
   logic [2:0]  len_in;
   logic        ok_in;

   // helpers
   logic [4:0]  top_pos;
   logic [4:0]  thumb_sh;
   logic [4:0]  arm_sh;
   logic [31:0] thumb_mask;
   logic [31:0] arm_mask;
   logic        thumb_ok;
   logic [11:0] thumb_imm12;
   logic        vfp_ok;
   logic [7:0]  vfp_imm8;
   logic        arm_ok;
   logic [3:0]  arm_rot;
   logic [7:0]  arm_byte;
   logic        s_pc_bad;

   // handshake: result register frees when empty or taken
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign move_out  = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take_in   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in) begin
         op_ff <= req_operation;
         rd_ff <= req_dest_register;
         s_ff  <= req_set_flags;
         v_ff  <= req_immediate;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move_out) begin
         enc_ff <= enc_in;
         len_ff <= len_in;
         ok_ff  <= ok_in;
      end
   end

   // highest set bit of the immediate (priority encoder)
   always_comb begin
      top_pos = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (v_ff[i]) top_pos = 5'(i);
      end
   end

   // shift amounts for the rounding and thumb shifted forms (valid when v >= 256)
   assign thumb_sh   = top_pos - 5'd7;
   assign arm_sh     = thumb_sh + {4'd0, thumb_sh[0]};
   assign thumb_mask = '1 << thumb_sh;
   assign arm_mask   = '1 << arm_sh;

   // thumb modified immediate search
   always_comb begin
      thumb_ok    = 1'b0;
      thumb_imm12 = 12'd0;
      if (v_ff < 32'd256) begin
         thumb_ok    = 1'b1;
         thumb_imm12 = {4'd0, v_ff[7:0]};
      end else if (v_ff[7:0] != 8'd0 && v_ff == {8'd0, v_ff[7:0], 8'd0, v_ff[7:0]}) begin
         // 00XY00XY
         thumb_ok    = 1'b1;
         thumb_imm12 = {4'b0001, v_ff[7:0]};
      end else if (v_ff[15:8] != 8'd0 && v_ff == {v_ff[15:8], 8'd0, v_ff[15:8], 8'd0}) begin
         // XY00XY00
         thumb_ok    = 1'b1;
         thumb_imm12 = {4'b0010, v_ff[15:8]};
      end else if (v_ff[7:0] != 8'd0 && v_ff == {4{v_ff[7:0]}}) begin
         // XYXYXYXY
         thumb_ok    = 1'b1;
         thumb_imm12 = {4'b0011, v_ff[7:0]};
      end else if ((v_ff & ~thumb_mask) == 32'd0) begin
         // rotated 8-bit value with implicit top one
         thumb_ok    = 1'b1;
         thumb_imm12 = {5'(5'd7 - top_pos), 7'(v_ff >> thumb_sh)};
      end
   end

   // vfp 8-bit float immediate
   always_comb begin
      vfp_ok   = 1'b0;
      vfp_imm8 = 8'd0;
      if (v_ff[18:0] == 19'd0) begin
         if (v_ff[30:25] == VFP_EXP_ONE_L) begin
            vfp_ok   = 1'b1;
            vfp_imm8 = {v_ff[31], 1'b1, v_ff[24:19]};
         end else if (v_ff[30:25] == VFP_EXP_ZERO_L) begin
            vfp_ok   = 1'b1;
            vfp_imm8 = {v_ff[31], 1'b0, v_ff[24:19]};
         end
      end
   end

   // arm rotated immediate: sixteen rotation checks, smallest rotation wins
   always_comb begin
      logic [63:0] rot64;
      arm_ok   = 1'b0;
      arm_rot  = 4'd0;
      arm_byte = 8'd0;
      for (int r = 15; r >= 0; r--) begin
         rot64 = {v_ff, v_ff} << (2 * r);
         if (rot64[63:40] == 24'd0) begin
            arm_ok   = 1'b1;
            arm_rot  = 4'(r);
            arm_byte = rot64[39:32];
         end
      end
   end

   assign s_pc_bad = s_ff && rd_ff == 8'd15;

   // per-operation encoding; failure leaves everything zero
   always_comb begin
      enc_in = 32'd0;
      len_in = movimm_pkg::LEN_NONE;
      ok_in  = 1'b0;
      unique case (movimm_pkg::opcode_type'(op_ff)) inside
         movimm_pkg::OP_T1MOV: begin
            if (rd_ff <= 8'd7 && v_ff <= 32'd255) begin
               enc_in = {16'd0, movimm_pkg::T1_MOVS_HI | {5'd0, rd_ff[2:0]}, v_ff[7:0]};
               len_in = movimm_pkg::LEN_NARROW;
               ok_in  = 1'b1;
            end
         end
         movimm_pkg::OP_T2MOV: begin
            if (rd_ff <= 8'd15 && !s_pc_bad && thumb_ok) begin
               enc_in = {1'b0, thumb_imm12[10:8], rd_ff[3:0],
                         thumb_imm12[7:0],
                         movimm_pkg::T2_MOV_HI | {5'd0, thumb_imm12[11], 2'd0},
                         movimm_pkg::T2_MOV_LO | {3'd0, s_ff, 4'd0}};
               len_in = movimm_pkg::LEN_WIDE;
               ok_in  = 1'b1;
            end
         end
         movimm_pkg::OP_T3MOVW, movimm_pkg::OP_MOVT: begin
            if (rd_ff <= 8'd14 && v_ff <= 32'hFFFF) begin
               enc_in = {1'b0, v_ff[10:8], rd_ff[3:0],
                         v_ff[7:0],
                         movimm_pkg::T3_MOVW_HI | {5'd0, v_ff[11], 2'd0},
                         ((op_ff == movimm_pkg::OP_T3MOVW) ? movimm_pkg::MOVW_LO
                                                           : movimm_pkg::MOVT_LO)
                            | {4'd0, v_ff[15:12]}};
               len_in = movimm_pkg::LEN_WIDE;
               ok_in  = 1'b1;
            end
         end
         movimm_pkg::OP_VMOVF32: begin
            if (rd_ff <= 8'd31 && vfp_ok) begin
               enc_in = {rd_ff[4:1], movimm_pkg::VMOV_COPROC,
                         4'd0, vfp_imm8[3:0],
                         movimm_pkg::VMOV_HI,
                         movimm_pkg::VMOV_LO | {1'b0, rd_ff[0], 2'd0, vfp_imm8[7:4]}};
               len_in = movimm_pkg::LEN_WIDE;
               ok_in  = 1'b1;
            end
         end
         movimm_pkg::OP_A1MOV: begin
            if (rd_ff <= 8'd15 && !s_pc_bad && arm_ok) begin
               enc_in = {movimm_pkg::ARM_COND_AL,
                         movimm_pkg::A1_MOV_B2 | {3'd0, s_ff, 4'd0},
                         rd_ff[3:0], arm_rot,
                         arm_byte};
               len_in = movimm_pkg::LEN_WIDE;
               ok_in  = 1'b1;
            end
         end
         movimm_pkg::OP_A2MOVW: begin
            if (rd_ff <= 8'd14 && v_ff <= 32'hFFFF) begin
               enc_in = {movimm_pkg::ARM_COND_AL,
                         4'd0, v_ff[15:12],
                         rd_ff[3:0], v_ff[11:8],
                         v_ff[7:0]};
               len_in = movimm_pkg::LEN_WIDE;
               ok_in  = 1'b1;
            end
         end
         movimm_pkg::OP_BKPT: begin
            enc_in = {16'd0, movimm_pkg::BKPT_HI, 8'd0};
            len_in = movimm_pkg::LEN_NARROW;
            ok_in  = 1'b1;
         end
         movimm_pkg::OP_NOP: begin
            enc_in = {16'd0, movimm_pkg::NOP_HI, 8'd0};
            len_in = movimm_pkg::LEN_NARROW;
            ok_in  = 1'b1;
         end
         movimm_pkg::OP_THUMBROUND: begin
            // keep the top eight significant bits
            enc_in = (v_ff < 32'd256) ? v_ff : (v_ff & thumb_mask);
            len_in = movimm_pkg::LEN_WIDE;
            ok_in  = 1'b1;
         end
         movimm_pkg::OP_ARMROUND: begin
            // same, with the cut point moved up to an even bit
            enc_in = (v_ff < 32'd256) ? v_ff : (v_ff & arm_mask);
            len_in = movimm_pkg::LEN_WIDE;
            ok_in  = 1'b1;
         end
         default: begin
            // unknown operation codes fail
            enc_in = 32'd0;
            len_in = movimm_pkg::LEN_NONE;
            ok_in  = 1'b0;
         end
      endcase
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_encoded      = enc_ff;
   assign rsp_length_bytes = len_ff;
   assign rsp_ok           = ok_ff;

endmodule

### design/movimm_checker.sv
// port-level checks for the move-immediate instruction encoder
// depends on movimm_pkg; bound to mov_immediate_instruction_encoder_unit below

module movimm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_encoded,
   input logic [2:0]  rsp_length_bytes,
   input logic        rsp_ok
);

   // a waiting item stays and holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_encoded)
         && $stable(rsp_length_bytes) && $stable(rsp_ok))
      else $error("stalled result item changed");

   // a good item is two or four bytes long
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ok |->
         rsp_length_bytes == movimm_pkg::LEN_NARROW || rsp_length_bytes == movimm_pkg::LEN_WIDE)
      else $error("good item with bad length");

   // a failed item carries nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |->
         rsp_encoded == 32'd0 && rsp_length_bytes == movimm_pkg::LEN_NONE)
      else $error("failed item not cleared");

   // narrow instructions leave the upper half empty
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_bytes == movimm_pkg::LEN_NARROW |-> rsp_encoded[31:16] == 16'd0)
      else $error("narrow item with upper bytes set");

endmodule

bind mov_immediate_instruction_encoder_unit movimm_checker u_movimm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_encoded      (rsp_encoded),
   .rsp_length_bytes (rsp_length_bytes),
   .rsp_ok           (rsp_ok)
);

### tb/sv/movimm_tb_pkg.sv
// item and result types plus the scoreboard for the move-immediate encoder bench
// depends on movimm_pkg for operation codes, opcode bytes and length codes

package movimm_tb_pkg;
   import movimm_pkg::*;

   // operation codes the block does not implement
   localparam logic [3:0] OP_UNUSED_FIRST = 4'd11;
   localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;

   // highest destination register each form accepts
   localparam int RD_LIMIT_T1   = 7;
   localparam int RD_LIMIT_CORE = 15;
   localparam int RD_LIMIT_WIDE = 14;
   localparam int RD_LIMIT_VFP  = 31;
   localparam int PC_REGISTER   = 15;

   typedef struct packed {
      logic [3:0]  operation;
      logic [7:0]  dest_register;
      logic        set_flags;
      logic [31:0] immediate;
   } movimm_item_t;

   typedef struct packed {
      logic [31:0] encoded;
      logic [2:0]  length_bytes;
      logic        ok;
   } movimm_image_t;

   class encode_scoreboard;
      movimm_image_t expected_images[$];
      int            mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int highest_set_bit(logic [31:0] v);
         int p;
         p = 0;
         for (int i = 0; i < 32; i++)
            if (v[i]) p = i;
         return p;
      endfunction

      // smallest thumb modified immediate whose expansion gives v
      function bit thumb_modified_imm(logic [31:0] v, output logic [11:0] imm12);
         logic [7:0]  b;
         logic [4:0]  rot;
         logic [31:0] shifted;
         int          p;
         imm12 = '0;
         if (v < 32'd256) begin
            imm12 = v[11:0];
            return 1'b1;
         end
         b = v[7:0];
         if (b != 8'd0 && v == {8'd0, b, 8'd0, b}) begin
            imm12 = {4'h1, b};
            return 1'b1;
         end
         b = v[15:8];
         if (b != 8'd0 && v == {b, 8'd0, b, 8'd0}) begin
            imm12 = {4'h2, b};
            return 1'b1;
         end
         b = v[7:0];
         if (b != 8'd0 && v == {4{b}}) begin
            imm12 = {4'h3, b};
            return 1'b1;
         end
         p = highest_set_bit(v);
         if ((v & ((32'd1 << (p - 7)) - 32'd1)) != 32'd0)
            return 1'b0;
         rot = 5'(39 - p);
         shifted = v >> (p - 7);
         imm12 = {rot, shifted[6:0]};
         return 1'b1;
      endfunction

      function bit vfp_imm8(logic [31:0] v, output logic [7:0] imm8);
         logic [5:0] e;
         logic       b6;
         imm8 = '0;
         e = v[30:25];
         if (v[18:0] != 19'd0)
            return 1'b0;
         if (e == VFP_EXP_ONE)
            b6 = 1'b1;
         else if (e == VFP_EXP_ZERO)
            b6 = 1'b0;
         else
            return 1'b0;
         imm8 = {v[31], b6, v[24:19]};
         return 1'b1;
      endfunction

      // arm rotated immediate, smallest rotation first
      function bit arm_rotated_imm(logic [31:0] v, output logic [11:0] imm12);
         logic [31:0] x;
         logic [3:0]  r;
         imm12 = '0;
         for (int rot = 0; rot < 16; rot++) begin
            x = (v << (2 * rot)) | (v >> (32 - 2 * rot));
            if (x <= 32'hFF) begin
               r = 4'(rot);
               imm12 = {r, x[7:0]};
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function movimm_image_t predict_encoding(movimm_item_t it);
         movimm_image_t img;
         logic [31:0]   v;
         logic [7:0]    rd;
         logic          s;
         logic [11:0]   imm12;
         logic [7:0]    imm8;
         logic [7:0]    lo;
         int            sh;
         v   = it.immediate;
         rd  = it.dest_register;
         s   = it.set_flags;
         img = '0;
         case (it.operation)
            OP_T1MOV: if (rd <= RD_LIMIT_T1 && v <= 32'hFF) begin
               img.encoded = {16'h0000, T1_MOVS_HI | rd, v[7:0]};
               img.length_bytes = LEN_NARROW;
               img.ok = 1'b1;
            end
            OP_T2MOV: if (rd <= RD_LIMIT_CORE && !(s && rd == PC_REGISTER)
                          && thumb_modified_imm(v, imm12)) begin
               img.encoded = {1'b0, imm12[10:8], rd[3:0], imm12[7:0],
                              T2_MOV_HI | {5'd0, imm12[11], 2'd0},
                              T2_MOV_LO | {3'd0, s, 4'd0}};
               img.length_bytes = LEN_WIDE;
               img.ok = 1'b1;
            end
            OP_T3MOVW, OP_MOVT: if (rd <= RD_LIMIT_WIDE && v <= 32'hFFFF) begin
               lo = (it.operation == OP_T3MOVW) ? MOVW_LO : MOVT_LO;
               img.encoded = {1'b0, v[10:8], rd[3:0], v[7:0],
                              T3_MOVW_HI | {5'd0, v[11], 2'd0},
                              lo | {4'd0, v[15:12]}};
               img.length_bytes = LEN_WIDE;
               img.ok = 1'b1;
            end
            OP_VMOVF32: if (rd <= RD_LIMIT_VFP && vfp_imm8(v, imm8)) begin
               img.encoded = {rd[4:1], VMOV_COPROC, 4'd0, imm8[3:0], VMOV_HI,
                              VMOV_LO | {1'b0, rd[0], 2'd0, imm8[7:4]}};
               img.length_bytes = LEN_WIDE;
               img.ok = 1'b1;
            end
            OP_A1MOV: if (rd <= RD_LIMIT_CORE && !(s && rd == PC_REGISTER)
                          && arm_rotated_imm(v, imm12)) begin
               img.encoded = {ARM_COND_AL, A1_MOV_B2 | {3'd0, s, 4'd0},
                              rd[3:0], imm12[11:8], imm12[7:0]};
               img.length_bytes = LEN_WIDE;
               img.ok = 1'b1;
            end
            OP_A2MOVW: if (rd <= RD_LIMIT_WIDE && v <= 32'hFFFF) begin
               img.encoded = {ARM_COND_AL, 4'd0, v[15:12], rd[3:0], v[11:8], v[7:0]};
               img.length_bytes = LEN_WIDE;
               img.ok = 1'b1;
            end
            OP_BKPT: begin
               img.encoded = {16'h0000, BKPT_HI, 8'h00};
               img.length_bytes = LEN_NARROW;
               img.ok = 1'b1;
            end
            OP_NOP: begin
               img.encoded = {16'h0000, NOP_HI, 8'h00};
               img.length_bytes = LEN_NARROW;
               img.ok = 1'b1;
            end
            OP_THUMBROUND, OP_ARMROUND: begin
               if (v < 32'd256) begin
                  img.encoded = v;
               end else begin
                  sh = highest_set_bit(v) - 7;
                  if (it.operation == OP_ARMROUND) sh += sh & 1;
                  img.encoded = v & ~((32'd1 << sh) - 32'd1);
               end
               img.length_bytes = LEN_WIDE;
               img.ok = 1'b1;
            end
            default: img = '0;
         endcase
         return img;
      endfunction

      function void note_request(movimm_item_t it);
         expected_images.push_back(predict_encoding(it));
      endfunction

      function void check_result(logic [31:0] encoded, logic [2:0] length_bytes, logic ok);
         movimm_image_t want;
         if (expected_images.size() == 0) begin
            $error("unexpected result: encoded %h length_bytes %0d ok %b",
                   encoded, length_bytes, ok);
            mismatches++;
            return;
         end
         want = expected_images.pop_front();
         if (encoded !== want.encoded) begin
            $error("encoded: expected %h, actual %h", want.encoded, encoded);
            mismatches++;
         end
         if (length_bytes !== want.length_bytes) begin
            $error("length_bytes: expected %0d, actual %0d", want.length_bytes, length_bytes);
            mismatches++;
         end
         if (ok !== want.ok) begin
            $error("ok: expected %b, actual %b", want.ok, ok);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_images.size();
      endfunction
   endclass

endpackage

### tb/sv/testbench.sv
// top-level bench for mov_immediate_instruction_encoder_unit: directed and random items,
// random idling on both channels, results checked in order against a scoreboard
// depends on movimm_pkg and movimm_tb_pkg

module testbench;
   import movimm_pkg::*;
   import movimm_tb_pkg::*;

   localparam int RANDOM_ITEMS   = 450;
   localparam int QUIET_ITEMS    = 60;    // tail of the run with no idling
   localparam int LONG_HOLD      = 120;   // receiver hold-off, fills the block
   localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
   localparam int TAIL_CYCLES    = 8;     // margin after the last result is checked

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_operation = '0;
   logic [7:0]  req_dest_register = '0;
   logic        req_set_flags = 1'b0;
   logic [31:0] req_immediate = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_encoded;
   logic [2:0]  rsp_length_bytes;
   logic        rsp_ok;

   // quiet turns off idling on both sides; hold_request asks the receiver for a long hold
   logic        quiet = 1'b0;
   logic        hold_request = 1'b0;
   int          idle_cycles = 0;

   encode_scoreboard sb;

   mov_immediate_instruction_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_dest_register(req_dest_register),
      .req_set_flags    (req_set_flags),
      .req_immediate    (req_immediate),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_encoded      (rsp_encoded),
      .rsp_length_bytes (rsp_length_bytes),
      .rsp_ok           (rsp_ok)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random stall bursts, or one long hold when asked
   // the long hold is counted here so the sender keeps offering items meanwhile
   initial begin : rsp_receiver
      int burst;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (burst) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // result monitor: values sampled here are the ones present before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_encoded, rsp_length_bytes, rsp_ok);
   end

   // watchdog on transfers, so a hung handshake ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   function automatic movimm_item_t make_item(logic [3:0] op, logic [7:0] rd, logic s,
                                              logic [31:0] imm);
      movimm_item_t it;
      it.operation     = op;
      it.dest_register = rd;
      it.set_flags     = s;
      it.immediate     = imm;
      return it;
   endfunction

   // mostly well-formed items: legal registers and immediates built to be encodable,
   // with a share of out-of-range registers, raw immediates and unused codes
   function automatic movimm_item_t random_item();
      movimm_item_t it;
      logic [7:0]   b;
      logic [31:0]  wide;
      logic         x;
      int           k;
      it.operation     = 4'($urandom_range(OP_T1MOV, OP_ARMROUND));
      it.dest_register = 8'($urandom_range(0, 255));
      it.set_flags     = 1'($urandom_range(0, 1));
      it.immediate     = $urandom;
      if ($urandom_range(0, 19) == 0) begin
         it.operation = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
         return it;
      end
      b = 8'($urandom_range(1, 255));
      k = $urandom_range(0, 15);
      case (it.operation)
         OP_T1MOV: begin
            it.dest_register = 8'($urandom_range(0, RD_LIMIT_T1));
            it.immediate = $urandom_range(0, 255);
         end
         OP_T2MOV: begin
            it.dest_register = 8'($urandom_range(0, RD_LIMIT_CORE));
            // one of the four replicated forms, or a shifted byte with its top bit set
            case (k % 5)
               0: it.immediate = $urandom_range(0, 255);
               1: it.immediate = {8'd0, b, 8'd0, b};
               2: it.immediate = {b, 8'd0, b, 8'd0};
               3: it.immediate = {4{b}};
               default: it.immediate = {24'd0, 1'b1, b[6:0]} << $urandom_range(1, 24);
            endcase
         end
         OP_T3MOVW, OP_MOVT, OP_A2MOVW: begin
            it.dest_register = 8'($urandom_range(0, RD_LIMIT_WIDE));
            it.immediate = $urandom_range(0, 16'hFFFF);
         end
         OP_VMOVF32: begin
            // exponent field must be 0x1f or 0x20, low mantissa clear
            it.dest_register = 8'($urandom_range(0, RD_LIMIT_VFP));
            x = 1'($urandom_range(0, 1));
            it.immediate = {b[7], ~x, {5{x}}, b[5:0], 19'd0};
         end
         OP_A1MOV: begin
            it.dest_register = 8'($urandom_range(0, RD_LIMIT_CORE));
            wide = {24'd0, b};
            it.immediate = (wide >> (2 * k)) | (wide << (32 - 2 * k));
         end
         OP_THUMBROUND, OP_ARMROUND: it.immediate = $urandom >> $urandom_range(0, 31);
         default: ;
      endcase
      if ($urandom_range(0, 9) == 0) it.dest_register = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) it.immediate = $urandom;
      return it;
   endfunction

   // offer one item, with an occasional idle burst first; returns once it is taken
   task automatic send_item(input movimm_item_t it);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= it.operation;
      req_dest_register <= it.dest_register;
      req_set_flags     <= it.set_flags;
      req_immediate     <= it.immediate;
      do @(posedge clock); while (req_stall);
      sb.note_request(it);
   endtask

   // sender pause until every expected result is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   initial begin : stimulus
      movimm_item_t directed[$];
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // field extremes, every operation, range and flag failures, unencodable values
      directed.push_back(make_item(OP_T1MOV, 8'd7, 1'b0, 32'h0000_00FF));
      directed.push_back(make_item(OP_T1MOV, 8'd8, 1'b1, 32'h0000_0000));
      directed.push_back(make_item(OP_T1MOV, 8'd0, 1'b0, 32'h0000_0100));
      directed.push_back(make_item(OP_T2MOV, 8'd0, 1'b1, 32'h00AB_00AB));
      directed.push_back(make_item(OP_T2MOV, 8'd3, 1'b0, 32'hAB00_AB00));
      directed.push_back(make_item(OP_T2MOV, 8'd9, 1'b1, 32'hFFFF_FFFF));
      directed.push_back(make_item(OP_T2MOV, 8'd15, 1'b0, 32'h8000_0000));
      directed.push_back(make_item(OP_T2MOV, 8'd15, 1'b1, 32'h0000_00FF));
      directed.push_back(make_item(OP_T2MOV, 8'd2, 1'b0, 32'h1234_5678));
      directed.push_back(make_item(OP_T3MOVW, 8'd14, 1'b0, 32'h0000_FFFF));
      directed.push_back(make_item(OP_MOVT, 8'd0, 1'b1, 32'h0000_8A5C));
      directed.push_back(make_item(OP_MOVT, 8'd15, 1'b0, 32'h0001_0000));
      directed.push_back(make_item(OP_VMOVF32, 8'd31, 1'b0, 32'h3F80_0000));
      directed.push_back(make_item(OP_VMOVF32, 8'd6, 1'b0, 32'hC000_0000));
      directed.push_back(make_item(OP_VMOVF32, 8'd32, 1'b0, 32'h3F80_0000));
      directed.push_back(make_item(OP_VMOVF32, 8'd1, 1'b0, 32'h3F80_0001));
      directed.push_back(make_item(OP_A1MOV, 8'd15, 1'b0, 32'hFF00_0000));
      directed.push_back(make_item(OP_A1MOV, 8'd15, 1'b1, 32'h0000_03FC));
      directed.push_back(make_item(OP_A1MOV, 8'd4, 1'b1, 32'h0000_0101));
      directed.push_back(make_item(OP_A2MOVW, 8'd14, 1'b1, 32'h0000_FFFF));
      directed.push_back(make_item(OP_A2MOVW, 8'd3, 1'b0, 32'h0001_0000));
      directed.push_back(make_item(OP_BKPT, 8'hFF, 1'b1, 32'hFFFF_FFFF));
      directed.push_back(make_item(OP_NOP, 8'hA5, 1'b0, 32'h5A5A_5A5A));
      directed.push_back(make_item(OP_THUMBROUND, 8'd0, 1'b0, 32'hFFFF_FFFF));
      directed.push_back(make_item(OP_THUMBROUND, 8'd0, 1'b0, 32'h0000_00FF));
      directed.push_back(make_item(OP_ARMROUND, 8'd0, 1'b0, 32'h0000_01FF));
      directed.push_back(make_item(OP_UNUSED_LAST, 8'd0, 1'b0, 32'h0000_0000));
      foreach (directed[i]) send_item(directed[i]);
      drain();

      // random part: one long receiver hold, one full drain, quiet tail
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) hold_request = 1'b1;
         if (n == 2 * RANDOM_ITEMS / 3) drain();
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         send_item(random_item());
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
